// ===== hdl/kufe_pkg.sv =====
package kufe_pkg;

  // Fixed field widths of the block
  localparam int CFG_BITS      = 11;
  localparam int COUNT_BITS    = 10;
  localparam int TOTAL_BITS    = 27;
  localparam int OUT_W_BITS    = 26;
  localparam int RANK_BITS     = 4;
  localparam int STATUS_BITS   = 3;

  // Reset value of the vertex count register
  localparam logic [CFG_BITS-1:0] CFG_RESET = 11'd1024;

  // Rank saturates here
  localparam logic [RANK_BITS-1:0] RANK_MAX = 4'd15;

  // Result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_ACCEPTED     = 3'd0,
    ST_SAME_SET     = 3'd1,
    ST_COMPLETE     = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_RESTARTED    = 3'd4
  } status_t;

endpackage

// ===== hdl/kufe_ram.sv =====
module kufe_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/kruskal_union_find_edge_filter.sv =====
// Kruskal edge filter over a disjoint-set forest (path compression, union by rank).
// Input channel (in_valid/in_ready): one item per transfer. in_mode 0 offers the
// edge in_end_a - in_end_b with in_edge_weight; user must sort by weight, unenforced.
// in_mode 1 restarts: every vertex back in its own set, count and total cleared.
// Result channel (out_valid/out_ready): one result per item with the status,
// the edge count, the tree weight and the tree-done flag after that item.
// cfg_we/cfg_wdata write the vertex count; write it only while idle.
// One item is worked at a time. Each endpoint of an edge is walked to its root
// and its path compressed, then the roots merge (plus a rank bump step when a
// rank grows); the path lengths from each endpoint to its root are bounded by
// log2 of the vertex count under union by rank. Each tree node costs one read and
// one compression write on the single RAM port pair. Complete and out-of-range
// edges go straight to the result step. A restart sweeps the whole forest memory
// before its result. in_ready rises as the result is loaded into the output
// register. After reset the same sweep runs before in_ready rises; cfg writes
// are taken during it. A stalled receiver holds the result in the output
// register; the next item is still taken and waits at its result step.
module kruskal_union_find_edge_filter #(
  parameter int MAX_VERTICES = 1024,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_mode,
  input  logic [$clog2(MAX_VERTICES)-1:0]       in_end_a,
  input  logic [$clog2(MAX_VERTICES)-1:0]       in_end_b,
  input  logic signed [WEIGHT_BITS-1:0]         in_edge_weight,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [kufe_pkg::STATUS_BITS-1:0]      out_status,
  output logic [kufe_pkg::COUNT_BITS-1:0]       out_edges_taken,
  output logic signed [kufe_pkg::OUT_W_BITS-1:0] out_tree_weight,
  output logic                                  out_tree_done,
  // configuration
  input  logic                                  cfg_we,
  input  logic [kufe_pkg::CFG_BITS-1:0]         cfg_wdata
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int RW = kufe_pkg::RANK_BITS;
  localparam int EW = VW + RW;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > kufe_pkg::CFG_BITS) ? NW : kufe_pkg::CFG_BITS;
  localparam int TB = kufe_pkg::TOTAL_BITS;

  typedef enum logic [6:0] {
    S_CLEAR    = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_FIND     = 7'b0000100,
    S_COMPRESS = 7'b0001000,
    S_MERGE    = 7'b0010000,
    S_BUMP     = 7'b0100000,
    S_RESULT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [kufe_pkg::CFG_BITS-1:0]   cfg_r;
  logic [VW-1:0]                   clr_r, clr_nxt;
  logic                            restart_r, restart_nxt;
  logic [VW-1:0]                   a_r, a_nxt, b_r, b_nxt;
  logic signed [WEIGHT_BITS-1:0]   w_r, w_nxt;
  logic [VW-1:0]                   cur_r, cur_nxt;
  logic                            phase_r, phase_nxt;
  logic [VW-1:0]                   ra_r, ra_nxt, rb_r, rb_nxt;
  logic [RW-1:0]                   rank_a_r, rank_a_nxt, rank_b_r, rank_b_nxt;
  logic [kufe_pkg::COUNT_BITS-1:0] count_r, count_nxt;
  logic [TB-1:0]                   total_r, total_nxt;
  kufe_pkg::status_t               status_r, status_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [kufe_pkg::STATUS_BITS-1:0] out_status_r;
  logic [kufe_pkg::COUNT_BITS-1:0] out_count_r;
  logic [kufe_pkg::OUT_W_BITS-1:0] out_weight_r;
  logic                            out_done_r;
  logic                            out_load;

  // RAM port signals and read forwarding
  logic          ram_we;
  logic [VW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic          fwd_hit_r;
  logic [EW-1:0] fwd_data_r;
  logic [EW-1:0] rd_ent;
  logic [VW-1:0] rd_par;
  logic [RW-1:0] rd_rank;

  // Active vertex count, saturated into 2..MAX_VERTICES
  logic [CW-1:0] cfg_ext, n_act, n_m1;
  logic          is_complete;
  logic [VW-1:0] start_v, root_v;
  logic [TB-1:0] w_ext;

  assign cfg_ext = CW'(cfg_r);
  always_comb begin
    if (cfg_ext < CW'(2)) begin
      n_act = CW'(2);
    end else if (cfg_ext > CW'(MAX_VERTICES)) begin
      n_act = CW'(MAX_VERTICES);
    end else begin
      n_act = cfg_ext;
    end
  end
  assign n_m1        = n_act - CW'(1);
  assign is_complete = CW'(count_r) >= n_m1;

  assign rd_ent  = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign rd_par  = rd_ent[EW-1:RW];
  assign rd_rank = rd_ent[RW-1:0];
  assign start_v = phase_r ? b_r : a_r;
  assign root_v  = phase_r ? rb_r : ra_r;
  assign w_ext   = TB'(w_r);

  assign in_ready = (state_r == S_IDLE);
  assign out_load = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    restart_nxt = restart_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    w_nxt       = w_r;
    cur_nxt     = cur_r;
    phase_nxt   = phase_r;
    ra_nxt      = ra_r;
    rb_nxt      = rb_r;
    rank_a_nxt  = rank_a_r;
    rank_b_nxt  = rank_b_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = cur_r;
    ram_wdata   = {root_v, rd_rank};

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {clr_r, RW'(0)};
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == VW'(MAX_VERTICES - 1)) begin
          clr_nxt = '0;
          if (restart_r) begin
            restart_nxt = 1'b0;
            status_nxt  = kufe_pkg::ST_RESTARTED;
            state_nxt   = S_RESULT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          a_nxt = in_end_a;
          b_nxt = in_end_b;
          w_nxt = in_edge_weight;
          if (in_mode) begin
            restart_nxt = 1'b1;
            count_nxt   = '0;
            total_nxt   = '0;
            state_nxt   = S_CLEAR;
          end else if (is_complete) begin
            status_nxt = kufe_pkg::ST_COMPLETE;
            state_nxt  = S_RESULT;
          end else if (CW'(in_end_a) >= n_act || CW'(in_end_b) >= n_act) begin
            status_nxt = kufe_pkg::ST_OUT_OF_RANGE;
            state_nxt  = S_RESULT;
          end else begin
            cur_nxt   = in_end_a;
            phase_nxt = 1'b0;
            state_nxt = S_FIND;
          end
        end
      end

      // Walk up the parent chain, one node per cycle
      S_FIND: begin
        if (rd_par == cur_r) begin
          if (!phase_r) begin
            ra_nxt     = cur_r;
            rank_a_nxt = rd_rank;
          end else begin
            rb_nxt     = cur_r;
            rank_b_nxt = rd_rank;
          end
          if (start_v != cur_r) begin
            cur_nxt   = start_v;
            state_nxt = S_COMPRESS;
          end else if (!phase_r) begin
            phase_nxt = 1'b1;
            cur_nxt   = b_r;
          end else begin
            state_nxt = S_MERGE;
          end
        end else begin
          cur_nxt = rd_par;
        end
      end

      // Second walk: point every node on the path at the root
      S_COMPRESS: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = {root_v, rd_rank};
        if (rd_par == root_v) begin
          if (!phase_r) begin
            phase_nxt = 1'b1;
            cur_nxt   = b_r;
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_MERGE;
          end
        end else begin
          cur_nxt = rd_par;
        end
      end

      // Union by rank, count and sum
      S_MERGE: begin
        if (ra_r == rb_r) begin
          status_nxt = kufe_pkg::ST_SAME_SET;
          state_nxt  = S_RESULT;
        end else begin
          ram_we     = 1'b1;
          count_nxt  = count_r + 1'b1;
          total_nxt  = total_r + w_ext;
          status_nxt = kufe_pkg::ST_ACCEPTED;
          state_nxt  = S_RESULT;
          if (rank_a_r > rank_b_r) begin
            ram_waddr = rb_r;
            ram_wdata = {ra_r, rank_b_r};
          end else begin
            ram_waddr = ra_r;
            ram_wdata = {rb_r, rank_a_r};
            if (rank_a_r == rank_b_r && rank_b_r != kufe_pkg::RANK_MAX) begin
              state_nxt = S_BUMP;
            end
          end
        end
      end

      S_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = rb_r;
        ram_wdata = {rb_r, rank_b_r + RW'(1)};
        state_nxt = S_RESULT;
      end

      S_RESULT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_r       <= kufe_pkg::CFG_RESET;
      clr_r       <= '0;
      restart_r   <= 1'b0;
      phase_r     <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      clr_r       <= clr_nxt;
      restart_r   <= restart_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_hit_r   <= ram_we && (ram_waddr == cur_nxt);
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    w_r        <= w_nxt;
    cur_r      <= cur_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    rank_a_r   <= rank_a_nxt;
    rank_b_r   <= rank_b_nxt;
    status_r   <= status_nxt;
    fwd_data_r <= ram_wdata;
    if (out_load) begin
      out_status_r <= status_r;
      out_count_r  <= count_r;
      out_weight_r <= total_r[kufe_pkg::OUT_W_BITS-1:0];
      out_done_r   <= is_complete;
    end
  end

  // Forest memory: {parent, rank} per vertex
  kufe_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_VERTICES)
  ) u_forest (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cur_nxt),
    .rdata(ram_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_edges_taken = out_count_r;
  assign out_tree_weight = out_weight_r;
  assign out_tree_done   = out_done_r;

`ifndef ASSERT_OFF
  // Only one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Compression never rewrites the root itself
  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMPRESS |-> cur_r != root_v)
    else $error("compression step on the root");

  // Rank bump only after merging two distinct roots of equal rank
  a_bump_equal: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BUMP |-> rank_a_r == rank_b_r && ra_r != rb_r && $past(state_r) == S_MERGE)
    else $error("rank bump without equal-rank merge");

  // A restart result reports an empty tree
  a_restart_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == kufe_pkg::ST_RESTARTED |->
      out_count_r == '0 && out_weight_r == '0 && !out_done_r)
    else $error("restart result not empty");
`endif

endmodule

// ===== tb/sv/kruskal_union_find_edge_filter_tb.sv =====
`timescale 1ns / 100ps

module kruskal_union_find_edge_filter_tb;

  localparam int NUM_VERTICES = 1024;
  localparam int VERTEX_BITS  = 10;
  localparam int WEIGHT_BITS  = 16;
  localparam int MAX_REPORTS  = 10;

  localparam logic MODE_EDGE    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MIN = 16'h8000;
  localparam logic signed [WEIGHT_BITS-1:0] WEIGHT_MAX = 16'h7fff;

  typedef logic [VERTEX_BITS-1:0]          vertex_t;
  typedef logic [kufe_pkg::CFG_BITS-1:0]   cfg_word_t;

  typedef struct {
    kufe_pkg::status_t                      status;
    logic [kufe_pkg::COUNT_BITS-1:0]        edges_taken;
    logic signed [kufe_pkg::OUT_W_BITS-1:0] tree_weight;
    logic                                   tree_done;
  } tree_result_t;

  // DUT ports
  logic                                   clk;
  logic                                   rst_n = 1'b0;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic                                   in_mode = MODE_EDGE;
  vertex_t                                in_end_a = '0;
  vertex_t                                in_end_b = '0;
  logic signed [WEIGHT_BITS-1:0]          in_edge_weight = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [kufe_pkg::STATUS_BITS-1:0]       out_status;
  logic [kufe_pkg::COUNT_BITS-1:0]        out_edges_taken;
  logic signed [kufe_pkg::OUT_W_BITS-1:0] out_tree_weight;
  logic                                   out_tree_done;
  logic                                   cfg_we = 1'b0;
  cfg_word_t                              cfg_wdata = '0;

  // predicted forest and tree state
  vertex_t                          forest_parent [NUM_VERTICES];
  logic [kufe_pkg::RANK_BITS-1:0]   forest_rank   [NUM_VERTICES];
  logic [kufe_pkg::COUNT_BITS-1:0]  tree_edges;
  logic [kufe_pkg::TOTAL_BITS-1:0]  tree_total;
  cfg_word_t                        vertex_limit;
  tree_result_t                     pending_results [$];

  // traffic shaping, percent of cycles
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;

  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int status_tally [8];

  kruskal_union_find_edge_filter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_end_a        (in_end_a),
    .in_end_b        (in_end_b),
    .in_edge_weight  (in_edge_weight),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_edges_taken (out_edges_taken),
    .out_tree_weight (out_tree_weight),
    .out_tree_done   (out_tree_done),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Forest predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_forest();
    int i;
    for (i = 0; i < NUM_VERTICES; i++) begin
      forest_parent[i] = vertex_t'(i);
      forest_rank[i]   = '0;
    end
    tree_edges = '0;
    tree_total = '0;
  endfunction

  // register value clamped to 2..NUM_VERTICES
  function automatic int unsigned used_vertices();
    if (vertex_limit < 2) return 2;
    if (vertex_limit > NUM_VERTICES) return NUM_VERTICES;
    return vertex_limit;
  endfunction

  // root of v's set; every node on the walk is pointed straight at it
  function automatic vertex_t find_set(vertex_t v);
    vertex_t root;
    vertex_t cur;
    vertex_t nxt;
    root = v;
    while (forest_parent[root] != root) root = forest_parent[root];
    cur = v;
    while (cur != root) begin
      nxt = forest_parent[cur];
      forest_parent[cur] = root;
      cur = nxt;
    end
    return root;
  endfunction

  // union by rank; on a tie the first root goes under the second
  function automatic void join_sets(vertex_t ra, vertex_t rb);
    if (forest_rank[ra] > forest_rank[rb]) begin
      forest_parent[rb] = ra;
    end else begin
      forest_parent[ra] = rb;
      if (forest_rank[ra] == forest_rank[rb] && forest_rank[rb] < kufe_pkg::RANK_MAX)
        forest_rank[rb] = forest_rank[rb] + 1'b1;
    end
  endfunction

  // advance the forest by one item and return the result it should produce
  function automatic tree_result_t filter_edge(logic mode, vertex_t a, vertex_t b,
                                               logic signed [WEIGHT_BITS-1:0] w);
    tree_result_t r;
    int unsigned  n;
    vertex_t      ra;
    vertex_t      rb;
    n = used_vertices();
    if (mode == MODE_RESTART) begin
      clear_forest();
      r.status = kufe_pkg::ST_RESTARTED;
    end else if (tree_edges >= n - 1) begin
      // tree complete wins over every other check
      r.status = kufe_pkg::ST_COMPLETE;
    end else if (a >= n || b >= n) begin
      r.status = kufe_pkg::ST_OUT_OF_RANGE;
    end else begin
      ra = find_set(a);
      rb = find_set(b);
      if (ra == rb) begin
        r.status = kufe_pkg::ST_SAME_SET;
      end else begin
        join_sets(ra, rb);
        tree_edges = tree_edges + 1'b1;
        tree_total = tree_total +
                     {{(kufe_pkg::TOTAL_BITS-WEIGHT_BITS){w[WEIGHT_BITS-1]}}, w};
        r.status = kufe_pkg::ST_ACCEPTED;
      end
    end
    r.edges_taken = tree_edges;
    r.tree_weight = tree_total[kufe_pkg::OUT_W_BITS-1:0];
    r.tree_done   = (tree_edges >= n - 1);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // valid stays up after a transfer; the next call either drops it or reloads it
  task automatic send_item(logic mode, vertex_t a, vertex_t b,
                           logic signed [WEIGHT_BITS-1:0] w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_end_a       <= a;
    in_end_b       <= b;
    in_edge_weight <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), filter_edge(mode, a, b, w));
    items_sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_vertex_count(cfg_word_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    vertex_limit = value;
  endtask

  // result side back-pressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin
    tree_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("result with nothing pending: status %0d edges %0d %s",
                                out_status, out_edges_taken,
                                $sformatf("weight %0d done %0b",
                                          out_tree_weight, out_tree_done)));
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        status_tally[want.status]++;
        if (out_status !== want.status || out_edges_taken !== want.edges_taken ||
            out_tree_weight !== want.tree_weight || out_tree_done !== want.tree_done)
          note_mismatch({$sformatf("result %0d: expected status %0d edges %0d weight %0d",
                                   results_checked, want.status, want.edges_taken,
                                   want.tree_weight),
                         $sformatf(" done %0b, got status %0d edges %0d weight %0d done %0b",
                                   want.tree_done, out_status, out_edges_taken,
                                   out_tree_weight, out_tree_done)});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // restart, then a mostly sorted edge stream with some noise mixed in
  task automatic run_forest(cfg_word_t cfg_value, int item_total);
    int unsigned n;
    int          pick;
    int          weight_now;
    vertex_t     a;
    vertex_t     b;
    wait_idle();
    write_vertex_count(cfg_value);
    n = used_vertices();
    send_item(MODE_RESTART, vertex_t'($urandom), vertex_t'($urandom), WEIGHT_BITS'($urandom));
    weight_now = $urandom_range(0, 40000) - 32768;
    repeat (item_total) begin
      pick = $urandom_range(99);
      a = vertex_t'($urandom_range(n - 1));
      b = vertex_t'($urandom_range(n - 1));
      if (pick < 80) begin
        // sorted stream: climb a little, clamp at the top
        weight_now = weight_now + $urandom_range(0, 400);
        if (weight_now > 32767) weight_now = 32767;
        send_item(MODE_EDGE, a, b, WEIGHT_BITS'(weight_now));
      end else if (pick < 88) begin
        // one endpoint anywhere in the index space
        if ($urandom_range(1)) a = vertex_t'($urandom);
        else b = vertex_t'($urandom);
        send_item(MODE_EDGE, a, b, WEIGHT_BITS'(weight_now));
      end else if (pick < 93) begin
        send_item(MODE_EDGE, a, a, WEIGHT_BITS'(weight_now));
      end else if (pick < 99) begin
        // out-of-order weight
        send_item(MODE_EDGE, a, b, WEIGHT_BITS'($urandom));
      end else begin
        send_item(MODE_RESTART, a, b, WEIGHT_BITS'($urandom));
        weight_now = $urandom_range(0, 40000) - 32768;
      end
    end
  endtask

  task automatic test_directed_cases();
    // full size: opposite corners, weight extremes, self loop, find through a chain
    send_item(MODE_EDGE, 10'd0,    10'd1023, WEIGHT_MIN);
    send_item(MODE_EDGE, 10'd1023, 10'd0,    WEIGHT_MIN);
    send_item(MODE_EDGE, 10'd5,    10'd5,    -16'sd100);
    send_item(MODE_EDGE, 10'd512,  10'd1023, 16'sd0);
    send_item(MODE_EDGE, 10'd511,  10'd512,  WEIGHT_MAX);
    send_item(MODE_EDGE, 10'd0,    10'd511,  WEIGHT_MAX);
    // weight below the last one is summed as given
    send_item(MODE_EDGE, 10'd7,    10'd3,    16'sd5);
    send_item(MODE_RESTART, 10'd1023, 10'd1023, WEIGHT_MAX);

    // four vertices: out of range, fill the tree, then complete
    wait_idle();
    write_vertex_count(11'd4);
    send_item(MODE_EDGE, 10'd0,    10'd4,    16'sd1);
    send_item(MODE_EDGE, 10'd1023, 10'd1,    16'sd1);
    send_item(MODE_EDGE, 10'd0,    10'd1,    16'sd2);
    send_item(MODE_EDGE, 10'd2,    10'd3,    16'sd2);
    send_item(MODE_EDGE, 10'd1,    10'd2,    16'sd3);
    send_item(MODE_EDGE, 10'd0,    10'd3,    16'sd4);
    // complete is checked ahead of range
    send_item(MODE_EDGE, 10'd1023, 10'd1023, 16'sd4);

    // smaller count under a full tree, then restart
    wait_idle();
    write_vertex_count(11'd3);
    send_item(MODE_EDGE, 10'd0, 10'd1, 16'sd5);
    send_item(MODE_RESTART, 10'd0, 10'd0, 16'sd0);

    // register below range acts as two vertices
    wait_idle();
    write_vertex_count(11'd0);
    send_item(MODE_EDGE, 10'd1, 10'd1, 16'sd5);
    send_item(MODE_EDGE, 10'd2, 10'd0, 16'sd5);
    send_item(MODE_EDGE, 10'd1, 10'd0, 16'sd6);
    send_item(MODE_EDGE, 10'd0, 10'd0, 16'sd6);

    // register above range acts as the full size
    wait_idle();
    write_vertex_count(11'd2047);
    send_item(MODE_RESTART, 10'd1023, 10'd0, WEIGHT_MIN);
    send_item(MODE_EDGE, 10'd1022, 10'd1023, 16'sd100);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    run_forest(11'd0, 8);
    run_forest(11'd1, 8);
    run_forest(11'd2, 8);
    run_forest(11'd2047, 8);
    run_forest(11'd1025, 8);
    run_forest(11'd3, 8);
    wait_idle();
  endtask

  task automatic test_random_forests(int budget);
    int vertices;
    int items;
    while (budget > 0) begin
      vertices = $urandom_range(2, 40);
      items = 2 * vertices + $urandom_range(4, 12);
      run_forest(cfg_word_t'(vertices), items);
      budget -= items + 1;
    end
    wait_idle();
  endtask

  // full index range on both endpoints
  task automatic test_full_forest();
    run_forest(11'd1024, 180);
    wait_idle();
  endtask

  initial begin
    clear_forest();
    vertex_limit = kufe_pkg::CFG_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_config_extremes();
    test_random_forests(260);

    send_gap_pct   = 84;
    recv_stall_pct = 0;
    test_random_forests(260);

    send_gap_pct   = 0;
    recv_stall_pct = 84;
    test_random_forests(260);

    send_gap_pct   = 21;
    recv_stall_pct = 21;
    test_random_forests(200);
    test_full_forest();

    wait_idle();
    repeat (50) @(posedge clk);

    $display("%0d items sent, %0d results checked, vertex counts 2..1024, four traffic mixes",
             items_sent, results_checked);
    $display("accepted %0d, same set %0d, complete %0d, out of range %0d, restarts %0d",
             status_tally[kufe_pkg::ST_ACCEPTED], status_tally[kufe_pkg::ST_SAME_SET],
             status_tally[kufe_pkg::ST_COMPLETE], status_tally[kufe_pkg::ST_OUT_OF_RANGE],
             status_tally[kufe_pkg::ST_RESTARTED]);
    if (mismatch_count == 0) begin
      $display("kruskal_union_find_edge_filter_tb OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("kruskal_union_find_edge_filter_tb NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(4_000_000);
    $display("timeout with %0d results pending", pending_results.size());
    $display("kruskal_union_find_edge_filter_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/kufe_pkg.sv
hdl/kufe_ram.sv
hdl/kruskal_union_find_edge_filter.sv
tb/sv/kruskal_union_find_edge_filter_tb.sv
